>>> design/flow_reset_rate_filter_assert.svh
// Assertion macros used by the checker file.
`ifndef FLOW_RESET_RATE_FILTER_ASSERT_SVH
`define FLOW_RESET_RATE_FILTER_ASSERT_SVH

// Check that a cause implies an effect in the next cycle.
`define FRRF_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");

// Check that a cause implies an effect in the same cycle.
`define FRRF_ASSERT_NOW(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("assertion failed");

`endif

>>> design/frrf_pkg.sv
// ----------------------------------------------------------------------------
// frrf_pkg
// Shared constants, types and SipHash round function for the rate filter.
// ----------------------------------------------------------------------------
package frrf_pkg;

    localparam int unsigned BUCKETS_DEFAULT = 4096;
    localparam int unsigned SIP_WORDS = 6;
    localparam int unsigned SIP_ROUNDS_TOTAL = 16; // 12 compress + 4 finalize

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] SIP_LEN_WORD = 64'h2800000000000000;
    localparam logic [3:0] BUCKET_FULL = 4'hF;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_RD1,
        ST_WR1,
        ST_RD2,
        ST_WR2,
        ST_OUT
    } state_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t t;
        t = s;
        t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 = t.v1 ^ t.v0;
        t.v0 = rotl(t.v0, 32);
        t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 = t.v3 ^ t.v2;
        t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 = t.v3 ^ t.v0;
        t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 = t.v1 ^ t.v2;
        t.v2 = rotl(t.v2, 32);
        sip_round = t;
    endfunction

endpackage

>>> design/frrf_siphash.sv
// ----------------------------------------------------------------------------
// frrf_siphash
// Iterative SipHash-2-4 over five words plus length word; one round a cycle.
// ----------------------------------------------------------------------------
module frrf_siphash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [63:0] w0,
    input  logic [63:0] w1,
    input  logic [63:0] w2,
    input  logic [63:0] w3,
    input  logic [63:0] w4,
    output logic        done,
    output logic [63:0] hash
);

    frrf_pkg::sip_state_t st_reg, st_next, rnd;
    logic [63:0] m_reg [5];
    logic [4:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] cur_m;
    logic [2:0]  widx;

    // Steps 0..11: two rounds per message word; 12..15: finalization.
    assign widx = step_reg[3:1];
    always_comb
    begin
        if (widx < 3'd5)
            cur_m = m_reg[widx];
        else
            cur_m = frrf_pkg::SIP_LEN_WORD;
    end

    always_comb
    begin
        frrf_pkg::sip_state_t pre;
        pre = st_reg;
        if (step_reg < 5'd12 && !step_reg[0])
            pre.v3 = pre.v3 ^ cur_m;
        if (step_reg == 5'd12)
            pre.v2 = pre.v2 ^ 64'hff;
        rnd = frrf_pkg::sip_round(pre);
        if (step_reg < 5'd12 && step_reg[0])
            rnd.v0 = rnd.v0 ^ cur_m;
    end

    always_comb
    begin
        st_next = st_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            st_next.v0 = key ^ frrf_pkg::SIP_C0;
            st_next.v1 = key ^ frrf_pkg::SIP_C1;
            st_next.v2 = key ^ frrf_pkg::SIP_C2;
            st_next.v3 = key ^ frrf_pkg::SIP_C3;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            st_next = rnd;
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(frrf_pkg::SIP_ROUNDS_TOTAL - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (start)
        begin
            m_reg[0] <= w0;
            m_reg[1] <= w1;
            m_reg[2] <= w2;
            m_reg[3] <= w3;
            m_reg[4] <= w4;
        end
    end

    assign done = busy_reg && (step_reg == 5'(frrf_pkg::SIP_ROUNDS_TOTAL - 1));
    assign hash = rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;

endmodule

>>> design/flow_reset_rate_filter.sv
// ----------------------------------------------------------------------------
// flow_reset_rate_filter
// Per-flow rate limiter for TCP resets using a counting bucket memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one flow tuple per word. The
//   output channel (out_valid/out_stall) returns one filter_out word per
//   input word; 1 means drop the reset, 0 means send it.
//   hash_seed is to be written via cfg_we/cfg_data only while the block
//   is idle; the block itself does not enforce this. Each item runs two
//   SipHash passes, each a start step and its rounds on one shared round
//   unit, and each pass is followed by a write-back step on the bucket
//   memory; the result is then offered. One item is in flight at a time:
//   once the result is taken the block returns to idle before the next
//   accept, so any output stall also holds off new input.
//   After reset all entries of the bucket memory (BUCKETS rounded up to a
//   power of two) are cleared one entry per cycle; no input is taken then.
//   A stalled result holds in the output register; input is held off until
//   it is taken.
// ----------------------------------------------------------------------------
module flow_reset_rate_filter
#(
    parameter int unsigned BUCKETS = frrf_pkg::BUCKETS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        is_ipv6,
    input  logic [63:0] source_high,
    input  logic [63:0] source_low,
    input  logic [63:0] dest_high,
    input  logic [63:0] dest_low,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        filter_out
);

    localparam int unsigned AW = (BUCKETS <= 2) ? 1 : $clog2(BUCKETS);
    localparam int unsigned DEPTH = 1 << AW;

    logic [3:0] mem [DEPTH];
    logic [3:0] rd_data_reg;

    frrf_pkg::state_t state_reg, state_next;
    logic [63:0] seed_reg;
    logic [31:0] decay_reg, decay_next;
    logic [AW:0] clr_reg, clr_next;
    logic        clearing;
    logic [63:0] w_reg [5];
    logic [AW-1:0] idx_reg, idx_next;
    logic        res_reg, res_next;
    logic        pass_reg, pass_next;
    logic [31:0] h1_reg, h1_next;

    logic        hs_start, hs_done;
    logic [63:0] hs_hash;
    logic [63:0] hw0, hw1;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [3:0]  mem_wdata;
    logic        in_acc;

    assign clearing = !clr_reg[AW];
    assign in_acc = in_valid && !in_stall;
    assign in_stall = clearing || (state_reg != frrf_pkg::ST_IDLE);
    assign out_valid = (state_reg == frrf_pkg::ST_OUT);
    assign filter_out = res_reg;

    // Second pass replaces the first two words.
    assign hw0 = pass_reg ? {32'd0, h1_reg} : w_reg[0];
    assign hw1 = pass_reg ? {32'd0, decay_reg} : w_reg[1];

    frrf_siphash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hs_start),
        .key   (seed_reg),
        .w0    (hw0),
        .w1    (hw1),
        .w2    (w_reg[2]),
        .w3    (w_reg[3]),
        .w4    (w_reg[4]),
        .done  (hs_done),
        .hash  (hs_hash)
    );

    always_comb
    begin
        state_next = state_reg;
        decay_next = decay_reg;
        clr_next = clr_reg;
        idx_next = idx_reg;
        res_next = res_reg;
        pass_next = pass_reg;
        h1_next = h1_reg;
        hs_start = 1'b0;
        mem_we = 1'b0;
        mem_addr = idx_reg;
        mem_wdata = rd_data_reg;
        if (clearing)
        begin
            mem_we = 1'b1;
            mem_addr = clr_reg[AW-1:0];
            mem_wdata = '0;
            clr_next = clr_reg + {{AW{1'b0}}, 1'b1};
        end
        unique case (state_reg)
            frrf_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    pass_next = 1'b0;
                    state_next = frrf_pkg::ST_HASH;
                end
            end
            frrf_pkg::ST_HASH:
            begin
                hs_start = 1'b1;
                state_next = frrf_pkg::ST_RD1;
            end
            frrf_pkg::ST_RD1:
            begin
                // wait for hash; issue read on the done cycle
                if (hs_done)
                begin
                    idx_next = hs_hash[AW-1:0];
                    if (!pass_reg)
                        h1_next = hs_hash[31:0];
                    state_next = pass_reg ? frrf_pkg::ST_WR2 : frrf_pkg::ST_WR1;
                end
            end
            frrf_pkg::ST_WR1:
            begin
                if (rd_data_reg == frrf_pkg::BUCKET_FULL)
                    res_next = 1'b1;
                else
                begin
                    res_next = 1'b0;
                    mem_we = 1'b1;
                    mem_wdata = rd_data_reg + 4'd1;
                end
                pass_next = 1'b1;
                state_next = frrf_pkg::ST_RD2;
            end
            frrf_pkg::ST_RD2:
            begin
                hs_start = 1'b1;
                decay_next = decay_reg + 32'd1;
                state_next = frrf_pkg::ST_RD1;
            end
            frrf_pkg::ST_WR2:
            begin
                if (rd_data_reg != 4'd0)
                begin
                    mem_we = 1'b1;
                    mem_wdata = rd_data_reg - 4'd1;
                end
                state_next = frrf_pkg::ST_OUT;
            end
            frrf_pkg::ST_OUT:
            begin
                if (!out_stall)
                    state_next = frrf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = frrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frrf_pkg::ST_IDLE;
            seed_reg <= '0;
            decay_reg <= '0;
            clr_reg <= '0;
            res_reg <= 1'b0;
            pass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                seed_reg <= cfg_data;
            decay_reg <= decay_next;
            clr_reg <= clr_next;
            res_reg <= res_next;
            pass_reg <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        h1_reg <= h1_next;
        if (in_acc)
        begin
            if (is_ipv6)
            begin
                w_reg[0] <= source_high;
                w_reg[1] <= source_low;
                w_reg[2] <= dest_high;
                w_reg[3] <= dest_low;
                w_reg[4] <= {32'd0, source_port, dest_port};
            end
            else
            begin
                w_reg[0] <= {32'd0, source_low[31:0]};
                w_reg[1] <= {48'd0, source_port};
                w_reg[2] <= {32'd0, dest_low[31:0]};
                w_reg[3] <= {48'd0, dest_port};
                w_reg[4] <= '0;
            end
        end
    end

    // Bucket memory: one write port, one registered read port. The read address is the
    // fresh hash on the done cycle so data is ready in the write state.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[(state_reg == frrf_pkg::ST_RD1) ? hs_hash[AW-1:0] : idx_reg];
    end

endmodule

>>> design/frrf_checker.sv
// ----------------------------------------------------------------------------
// frrf_checker
// Port-level checks on the rate filter handshakes.
// ----------------------------------------------------------------------------
`include "flow_reset_rate_filter_assert.svh"

module frrf_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic filter_out
);

    `FRRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(filter_out))
    `FRRF_ASSERT_NOW(a_no_in_while_out, clk, rst_n, out_valid, in_stall)
    `FRRF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)

endmodule

bind flow_reset_rate_filter frrf_checker u_frrf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .filter_out (filter_out)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives flow tuples into the reset rate filter and checks each filter_out
// word against a SipHash-2-4 counting-bucket predictor kept in step with it.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BUCKETS = 4096;
    localparam int unsigned IDX_BITS = $clog2(BUCKETS);
    localparam int unsigned IDX_MASK = (1 << IDX_BITS) - 1;
    // Allows for item processing, the clearing pass of BUCKETS entries, plus stalls
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned RANDOM_ITEMS = 1880;

    typedef struct packed {
        logic        is_ipv6;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } flow_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        is_ipv6 = 1'b0;
    logic [63:0] source_high = '0;
    logic [63:0] source_low = '0;
    logic [63:0] dest_high = '0;
    logic [63:0] dest_low = '0;
    logic [15:0] source_port = '0;
    logic [15:0] dest_port = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        filter_out;

    // Predictor state
    logic [63:0] seed_model = '0;
    logic [3:0]  bucket_model [BUCKETS];
    logic [31:0] decay_model = '0;

    flow_word_t pending_flows[$];
    logic       expected_verdicts[$];
    int         error_count = 0;
    int         verdicts_seen = 0;
    int         drops_seen = 0;
    int         quiet_cycles = 0;
    int         hold_cycles = 0;
    int         out_wait = 0;
    bit         long_hold = 1'b0;

    always #6 clk = ~clk;

    flow_reset_rate_filter #(.BUCKETS(BUCKETS)) DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .is_ipv6(is_ipv6),
        .source_high(source_high),
        .source_low(source_low),
        .dest_high(dest_high),
        .dest_low(dest_low),
        .source_port(source_port),
        .dest_port(dest_port),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .filter_out(filter_out)
    );

    function automatic logic [63:0] rol64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // SipHash-2-4 over five words plus the length word, key = {seed, seed}
    function automatic logic [63:0] siphash_flow(input logic [63:0] w [5],
                                                 input logic [63:0] seed);
        logic [63:0] a, b, c, d, m;
        a = seed ^ 64'h736f6d6570736575;
        b = seed ^ 64'h646f72616e646f6d;
        c = seed ^ 64'h6c7967656e657261;
        d = seed ^ 64'h7465646279746573;
        for (int i = 0; i < 6; i++)
        begin
            m = (i < 5) ? w[i] : 64'h2800000000000000;
            d ^= m;
            for (int r = 0; r < 2; r++)
            begin
                a += b; b = rol64(b, 13); b ^= a; a = rol64(a, 32);
                c += d; d = rol64(d, 16); d ^= c;
                a += d; d = rol64(d, 21); d ^= a;
                c += b; b = rol64(b, 17); b ^= c; c = rol64(c, 32);
            end
            a ^= m;
        end
        c ^= 64'hff;
        for (int r = 0; r < 4; r++)
        begin
            a += b; b = rol64(b, 13); b ^= a; a = rol64(a, 32);
            c += d; d = rol64(d, 16); d ^= c;
            a += d; d = rol64(d, 21); d ^= a;
            c += b; b = rol64(b, 17); b ^= c; c = rol64(c, 32);
        end
        return a ^ b ^ c ^ d;
    endfunction

    // Charge the flow's bucket, leak a pseudo-random one, return the verdict.
    function automatic logic rate_limit_verdict(input flow_word_t f);
        logic [63:0] w [5];
        logic [63:0] h;
        int unsigned idx;
        logic verdict;
        verdict = 1'b0;
        if (f.is_ipv6)
        begin
            w[0] = f.source_high;
            w[1] = f.source_low;
            w[2] = f.dest_high;
            w[3] = f.dest_low;
            w[4] = {32'd0, f.source_port, f.dest_port};
        end
        else
        begin
            w[0] = {32'd0, f.source_low[31:0]};
            w[1] = {48'd0, f.source_port};
            w[2] = {32'd0, f.dest_low[31:0]};
            w[3] = {48'd0, f.dest_port};
            w[4] = '0;
        end
        h = siphash_flow(w, seed_model);
        idx = h[31:0] & IDX_MASK;
        if (bucket_model[idx] == 4'hF)
            verdict = 1'b1;
        else
            bucket_model[idx] = bucket_model[idx] + 4'd1;
        w[0] = {32'd0, h[31:0]};
        w[1] = {32'd0, decay_model};
        decay_model = decay_model + 32'd1;
        h = siphash_flow(w, seed_model);
        idx = h[31:0] & IDX_MASK;
        if (bucket_model[idx] != 4'd0)
            bucket_model[idx] = bucket_model[idx] - 4'd1;
        return verdict;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic flow_word_t random_flow(input bit v6);
        flow_word_t f;
        f.is_ipv6 = v6;
        f.source_high = rand64();
        f.source_low = rand64();
        f.dest_high = rand64();
        f.dest_low = rand64();
        f.source_port = 16'($urandom_range(0, 65535));
        f.dest_port = 16'($urandom_range(0, 65535));
        return f;
    endfunction

    task automatic write_seed(input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        seed_model = value;
    endtask

    // Wait for every queued flow to be sent and every verdict to come back.
    task automatic drain_flows();
        while (pending_flows.size() != 0 || expected_verdicts.size() != 0 || in_valid)
            @(negedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Driver: present a flow, hold it while stalled, then idle for a random gap.
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_verdicts.push_back(rate_limit_verdict(
                    {is_ipv6, source_high, source_low, dest_high, dest_low,
                     source_port, dest_port}));
                gap_left = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    gap_left = 0;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left == 0 && pending_flows.size() != 0)
                begin
                    flow_word_t f;
                    f = pending_flows.pop_front();
                    in_valid <= 1'b1;
                    {is_ipv6, source_high, source_low, dest_high, dest_low,
                     source_port, dest_port} <= f;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Monitor: check each accepted verdict and set the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                verdicts_seen++;
                if (filter_out)
                    drops_seen++;
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict %0b", $time, filter_out);
                    error_count++;
                end
                else
                begin
                    logic exp_v;
                    exp_v = expected_verdicts.pop_front();
                    if (exp_v !== filter_out)
                    begin
                        $display("%0t: filter_out expected %0b actual %0b",
                                 $time, exp_v, filter_out);
                        error_count++;
                    end
                end
            end
            // Long hold-off lets the sender back up against in_stall.
            if (long_hold)
            begin
                out_stall <= 1'b1;
                long_hold = 1'b0;
                hold_cycles = 300;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= (hold_cycles != 0);
            end
            else if (out_valid && !out_stall)
            begin
                // Draw how long to hold off the next word.
                out_wait = $urandom_range(0, 3);
                out_stall <= (out_wait != 0);
            end
            else if (out_valid && out_stall)
            begin
                if (out_wait > 0)
                    out_wait--;
                out_stall <= (out_wait != 0);
            end
        end
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        flow_word_t f;
        int n;
        int repeat_count;
        for (int i = 0; i < BUCKETS; i++)
            bucket_model[i] = 4'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes with the reset seed.
        f = '0;
        pending_flows.push_back(f);
        f = '1;
        pending_flows.push_back(f);
        f.is_ipv6 = 1'b0;
        pending_flows.push_back(f);
        f = '0;
        f.is_ipv6 = 1'b1;
        pending_flows.push_back(f);
        // IPv4 upper address bits must not matter; same flow twice.
        f = random_flow(1'b0);
        pending_flows.push_back(f);
        f.source_low[63:32] = ~f.source_low[63:32];
        f.dest_high = ~f.dest_high;
        pending_flows.push_back(f);
        // One flow repeated until its bucket saturates and filters.
        f = random_flow(1'b1);
        repeat (19) pending_flows.push_back(f);
        drain_flows();

        // Random phases over several seeds, extremes included.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_seed(64'hFFFF_FFFF_FFFF_FFFF);
                1: write_seed(rand64());
                2: write_seed(64'd0);
                default: write_seed(rand64());
            endcase
            n = 0;
            while (n < RANDOM_ITEMS / 4)
            begin
                // Mostly repeated hot flows so buckets saturate and leak.
                if ($urandom_range(0, 2) != 0 && n > 0)
                    repeat_count = $urandom_range(1, 20);
                else
                begin
                    f = random_flow(1'($urandom_range(0, 1)));
                    repeat_count = 1;
                end
                for (int k = 0; k < repeat_count && n < RANDOM_ITEMS / 4; k++)
                begin
                    pending_flows.push_back(f);
                    n++;
                end
            end
            if (phase == 1)
                long_hold = 1'b1;
            drain_flows();
        end

        $display("Checked %0d filter verdicts (%0d filtered) over five seed settings.",
                 verdicts_seen, drops_seen);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> flow_reset_rate_filter.f
+incdir+design
design/frrf_pkg.sv
design/frrf_siphash.sv
design/flow_reset_rate_filter.sv
design/frrf_checker.sv
test/testbench.sv
